@@ design/murmur3_32_stream_hash_core_defines.svh @@
// Assertion macros used by the checker of the MurmurHash3 stream core.
// Include once; no other dependencies.
`ifndef MURMUR3_32_STREAM_HASH_CORE_DEFINES_SVH
`define MURMUR3_32_STREAM_HASH_CORE_DEFINES_SVH

// Clocked check, held off while reset is asserted.
`define MM3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define MM3_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/mm3_pkg.sv @@
// Shared constants and types of the MurmurHash3 stream core.
// No dependencies.
package mm3_pkg;

    localparam int WORD_W     = 32;
    localparam int CNT_W      = 3;
    localparam int IN_TDATA_W = 40;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [WORD_W-1:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] MIX_C2  = 32'h1b873593;
    localparam logic [WORD_W-1:0] MIX_ADD = 32'he6546b64;
    localparam logic [WORD_W-1:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] FIN_M2  = 32'hc2b2ae35;

    localparam logic [CNT_W-1:0] FULL_BYTES = 3'd4;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TAIL = 2'd1,
        KIND_FULL = 2'd2
    } kind_t;

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [CNT_W-1:0]  count;
        logic              last;
        kind_t             kind;
    } entry_t;

    typedef struct packed {
        logic not_full;
        logic not_empty;
    } q_stat_t;

endpackage

@@ design/mm3_front.sv @@
// Front end: accepts words, masks and classifies them, scrambles the key.
// Depends on mm3_pkg.
module mm3_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mm3_pkg::WORD_W-1:0]    in_word,
    input  logic [mm3_pkg::CNT_W-1:0]     in_count,
    input  logic                          in_last,
    input  mm3_pkg::q_stat_t              q_stat,
    output logic                          push,
    output mm3_pkg::entry_t               push_data
);

    logic                       en;
    logic [mm3_pkg::CNT_W-1:0]  cnt_sat;
    logic [mm3_pkg::WORD_W-1:0] mask;
    mm3_pkg::kind_t             kind;
    logic [mm3_pkg::WORD_W-1:0] k1_rot;

    logic                       s1_valid_reg;
    mm3_pkg::entry_t            s1_reg;
    logic                       s2_valid_reg;
    mm3_pkg::entry_t            s2_reg;

    assign en        = !s2_valid_reg || q_stat.not_full;
    assign in_ready  = en;
    assign push      = s2_valid_reg && q_stat.not_full;
    assign push_data = s2_reg;

    always_comb
    begin
        // saturate counts above a full word
        if (in_count inside {[3'd4:3'd7]})
            cnt_sat = mm3_pkg::FULL_BYTES;
        else
            cnt_sat = in_count;

        case (cnt_sat)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            3'd4:    mask = 32'hffff_ffff;
            default: mask = 32'h0000_0000;
        endcase

        if (cnt_sat == mm3_pkg::FULL_BYTES)
            kind = mm3_pkg::KIND_FULL;
        else if (cnt_sat == '0)
            kind = mm3_pkg::KIND_NONE;
        else
            kind = mm3_pkg::KIND_TAIL;

        k1_rot = {s1_reg.key[16:0], s1_reg.key[31:17]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.key   <= (in_word & mask) * mm3_pkg::MIX_C1;
            s1_reg.count <= cnt_sat;
            s1_reg.last  <= in_last;
            s1_reg.kind  <= kind;
            s2_reg.key   <= k1_rot * mm3_pkg::MIX_C2;
            s2_reg.count <= s1_reg.count;
            s2_reg.last  <= s1_reg.last;
            s2_reg.kind  <= s1_reg.kind;
        end
    end

endmodule

@@ design/mm3_queue.sv @@
// Short queue of scrambled words between front and back end.
// Depends on mm3_pkg.
module mm3_queue
#(
    parameter int DEPTH = mm3_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mm3_pkg::entry_t  push_data,
    input  logic             pop,
    output mm3_pkg::entry_t  pop_data,
    output mm3_pkg::q_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mm3_pkg::entry_t mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   fill_reg;
    logic            do_push;
    logic            do_pop;

    assign stat.not_full  = (fill_reg != CW'(DEPTH));
    assign stat.not_empty = (fill_reg != '0);
    assign do_push        = push && stat.not_full;
    assign do_pop         = pop && stat.not_empty;
    assign pop_data       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

@@ design/mm3_back.sv @@
// Back end: running hash and length update, finalization mix, result register.
// Depends on mm3_pkg; holds the seed register.
module mm3_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [mm3_pkg::WORD_W-1:0] cfg_data,
    input  mm3_pkg::entry_t            entry,
    input  mm3_pkg::q_stat_t           q_stat,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mm3_pkg::WORD_W-1:0] out_hash
);

    logic                       adv;
    logic                       take;
    logic [mm3_pkg::WORD_W-1:0] base_hash;
    logic [mm3_pkg::WORD_W-1:0] base_len;
    logic [mm3_pkg::WORD_W-1:0] mixed;
    logic [mm3_pkg::WORD_W-1:0] rot13;
    logic [mm3_pkg::WORD_W-1:0] hash_next;
    logic [mm3_pkg::WORD_W-1:0] len_next;
    logic [mm3_pkg::WORD_W-1:0] p0_mix;
    logic [mm3_pkg::WORD_W-1:0] p1_mix;
    logic [mm3_pkg::WORD_W-1:0] p2_mix;

    logic [mm3_pkg::WORD_W-1:0] seed_reg;
    logic                       in_msg_reg;
    logic [mm3_pkg::WORD_W-1:0] hash_reg;
    logic [mm3_pkg::WORD_W-1:0] len_reg;
    logic                       p0_valid_reg;
    logic                       p1_valid_reg;
    logic                       p2_valid_reg;
    logic                       out_valid_reg;
    logic [mm3_pkg::WORD_W-1:0] p0_reg;
    logic [mm3_pkg::WORD_W-1:0] p1_reg;
    logic [mm3_pkg::WORD_W-1:0] p2_reg;
    logic [mm3_pkg::WORD_W-1:0] out_reg;

    // the whole back pipeline moves in lockstep, held only by the result side
    assign adv       = !out_valid_reg || out_ready;
    assign take      = adv && q_stat.not_empty;
    assign pop       = take;
    assign out_valid = out_valid_reg;
    assign out_hash  = out_reg;

    always_comb
    begin
        // a new message starts from the seed with zero length
        base_hash = in_msg_reg ? hash_reg : seed_reg;
        base_len  = in_msg_reg ? len_reg : '0;
        mixed     = base_hash ^ entry.key;
        rot13     = {mixed[18:0], mixed[31:19]};
        case (entry.kind)
            mm3_pkg::KIND_FULL: hash_next = {rot13[29:0], 2'b00} + rot13 + mm3_pkg::MIX_ADD;
            mm3_pkg::KIND_TAIL: hash_next = mixed;
            default:            hash_next = base_hash;
        endcase
        len_next = base_len + mm3_pkg::WORD_W'(entry.count);
        p0_mix   = p0_reg ^ {16'b0, p0_reg[31:16]};
        p1_mix   = p1_reg ^ {13'b0, p1_reg[31:13]};
        p2_mix   = p2_reg ^ {16'b0, p2_reg[31:16]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            in_msg_reg    <= 1'b0;
            p0_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                seed_reg <= cfg_data;
            if (take)
                in_msg_reg <= !entry.last;
            if (adv)
            begin
                p0_valid_reg  <= take && entry.last;
                p1_valid_reg  <= p0_valid_reg;
                p2_valid_reg  <= p1_valid_reg;
                out_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hash_reg <= hash_next;
            len_reg  <= len_next;
        end
        if (adv)
        begin
            p0_reg  <= hash_next ^ len_next;
            p1_reg  <= p0_mix * mm3_pkg::FIN_M1;
            p2_reg  <= p1_mix * mm3_pkg::FIN_M2;
            out_reg <= p2_mix;
        end
    end

endmodule

@@ design/murmur3_32_stream_hash_core.sv @@
// MurmurHash3 x86_32 stream core. Path from the accepted last word to m_axis_tvalid:
// first and second key multiply stages, queue write, hash update, three finalize stages.
// Throughput: one word per cycle unless a stalled result output holds the back end and the queue fills.
// Reset: rst_n low clears all valids, the queue and the seed (0); no clearing pass.
// The seed write channel is always ready; a write reaches the next message begun.
module murmur3_32_stream_hash_core
#(
    parameter int QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // fields from bit 0: data_word[31:0], byte_count[34:32], zero pad [39:35]
    input  logic [mm3_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // fields from bit 0: hash[31:0]
    output logic [mm3_pkg::WORD_W-1:0]     m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mm3_pkg::WORD_W-1:0]     cfg_data
);

    mm3_pkg::q_stat_t q_stat;
    mm3_pkg::entry_t  push_data;
    mm3_pkg::entry_t  pop_data;
    logic             push;
    logic             pop;

    assign cfg_ready = 1'b1;

    mm3_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_word   (s_axis_tdata[31:0]),
        .in_count  (s_axis_tdata[34:32]),
        .in_last   (s_axis_tlast),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    mm3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    mm3_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .entry     (pop_data),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hash  (m_axis_tdata)
    );

endmodule

@@ design/mm3_checker.sv @@
// Port-level checks of the MurmurHash3 stream core, bound to the top level.
// Depends on murmur3_32_stream_hash_core_defines.svh.
`include "murmur3_32_stream_hash_core_defines.svh"

module mm3_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        cfg_ready
);

    logic       last_in;
    logic       word_out;
    logic [7:0] pending_reg;

    assign last_in  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign word_out = m_axis_tvalid && m_axis_tready;

    // count messages closed at the input but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (last_in && !word_out)
            pending_reg <= pending_reg + 1'b1;
        else if (word_out && !last_in)
            pending_reg <= pending_reg - 1'b1;
    end

    `MM3_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
    `MM3_ASSERT(a_out_owed, m_axis_tvalid |-> pending_reg != 8'd0, "result word without a closed message")
    `MM3_ASSERT(a_min_latency, last_in && pending_reg == 8'd0 && !m_axis_tvalid |=> !m_axis_tvalid, "result word too early")
    `MM3_ASSERT_ANY(a_reset_quiet, !rst_n |-> !m_axis_tvalid && cfg_ready, "result valid during reset")

endmodule

bind murmur3_32_stream_hash_core mm3_checker u_mm3_checker (.*);
